/* src/ftab_pkg.sv */
// ----------------------------------------------------------------------------
// ftab_pkg
// Shared codes, constants and control structs of the flow statistics table.
// ----------------------------------------------------------------------------
package ftab_pkg;

  typedef enum logic [2:0] {
    ST_NONE  = 3'd0,
    ST_CFULL = 3'd1,
    ST_RFULL = 3'd2,
    ST_RONLY = 3'd3,
    ST_FFULL = 3'd4,
    ST_FLOW  = 3'd5
  } stat_code_t;

  localparam logic [7:0]  PROTO_ICMP   = 8'd1;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [23:0] PREFIX_RESET = 24'hAC1F42;

  typedef struct packed {
    logic       load_in;
    logic       idx_clr;
    logic       idx_inc;
    logic       rd_client;
    logic       client_hit_load;
    logic       client_append;
    logic       rd_rcount;
    logic       rcount_load;
    logic       rd_remote;
    logic       remote_hit_load;
    logic       remote_append;
    logic       remote_update;
    logic       rd_flow;
    logic       flow_hit_load;
    logic       flow_append;
    logic       flow_update;
    logic       remote_write;
    logic       flow_write;
    logic       code_load;
    stat_code_t code;
    logic       out_load;
  } ftab_cmd_t;

  typedef struct packed {
    logic is_client;
    logic flow_proto;
    logic client_end;
    logic client_full;
    logic client_hit;
    logic remote_end;
    logic remote_full;
    logic remote_hit;
    logic flow_end;
    logic flow_full;
    logic flow_hit;
    logic out_free;
  } ftab_stat_t;

endpackage

/* src/ftab_ram.sv */
// ----------------------------------------------------------------------------
// ftab_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ftab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* src/ftab_ctrl.sv */
// ----------------------------------------------------------------------------
// ftab_ctrl
// Sequencer of the client, remote and flow searches and updates.
// ----------------------------------------------------------------------------
module ftab_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ftab_pkg::ftab_stat_t st,
  output ftab_pkg::ftab_cmd_t  cmd
);
  import ftab_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_CLASS = 15'b000000000000010,
    S_C_RD  = 15'b000000000000100,
    S_C_CMP = 15'b000000000001000,
    S_RC_RD = 15'b000000000010000,
    S_RC_WT = 15'b000000000100000,
    S_R_RD  = 15'b000000001000000,
    S_R_CMP = 15'b000000010000000,
    S_R_UPD = 15'b000000100000000,
    S_R_WR  = 15'b000001000000000,
    S_F_RD  = 15'b000010000000000,
    S_F_CMP = 15'b000100000000000,
    S_F_UPD = 15'b001000000000000,
    S_F_WR  = 15'b010000000000000,
    S_DONE  = 15'b100000000000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.code   = ST_NONE;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_CLASS;
        end
      end
      S_CLASS: begin
        cmd.idx_clr = 1'b1;
        if (st.is_client) begin
          state_next = S_C_RD;
        end else begin
          cmd.code_load = 1'b1;
          cmd.code      = ST_NONE;
          state_next    = S_DONE;
        end
      end
      S_C_RD: begin
        if (!st.client_end) begin
          cmd.rd_client = 1'b1;
          state_next    = S_C_CMP;
        end else if (st.client_full) begin
          cmd.code_load = 1'b1;
          cmd.code      = ST_CFULL;
          state_next    = S_DONE;
        end else begin
          cmd.client_append = 1'b1;
          cmd.idx_clr       = 1'b1;
          state_next        = S_R_RD;
        end
      end
      S_C_CMP: begin
        if (st.client_hit) begin
          cmd.client_hit_load = 1'b1;
          state_next          = S_RC_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_C_RD;
        end
      end
      S_RC_RD: begin
        cmd.rd_rcount = 1'b1;
        state_next    = S_RC_WT;
      end
      S_RC_WT: begin
        cmd.rcount_load = 1'b1;
        cmd.idx_clr     = 1'b1;
        state_next      = S_R_RD;
      end
      S_R_RD: begin
        if (!st.remote_end) begin
          cmd.rd_remote = 1'b1;
          state_next    = S_R_CMP;
        end else if (st.remote_full) begin
          cmd.code_load = 1'b1;
          cmd.code      = ST_RFULL;
          state_next    = S_DONE;
        end else begin
          cmd.remote_append = 1'b1;
          state_next        = S_R_UPD;
        end
      end
      S_R_CMP: begin
        if (st.remote_hit) begin
          cmd.remote_hit_load = 1'b1;
          state_next          = S_R_UPD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_R_RD;
        end
      end
      S_R_UPD: begin
        cmd.remote_update = 1'b1;
        cmd.idx_clr       = 1'b1;
        state_next        = st.flow_proto ? S_F_RD : S_R_WR;
      end
      S_R_WR: begin
        cmd.remote_write = 1'b1;
        cmd.code_load    = 1'b1;
        cmd.code         = ST_RONLY;
        state_next       = S_DONE;
      end
      S_F_RD: begin
        if (!st.flow_end) begin
          cmd.rd_flow = 1'b1;
          state_next  = S_F_CMP;
        end else if (st.flow_full) begin
          cmd.remote_write = 1'b1;
          cmd.code_load    = 1'b1;
          cmd.code         = ST_FFULL;
          state_next       = S_DONE;
        end else begin
          cmd.flow_append = 1'b1;
          state_next      = S_F_UPD;
        end
      end
      S_F_CMP: begin
        if (st.flow_hit) begin
          cmd.flow_hit_load = 1'b1;
          state_next        = S_F_UPD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_F_RD;
        end
      end
      S_F_UPD: begin
        cmd.flow_update = 1'b1;
        state_next      = S_F_WR;
      end
      S_F_WR: begin
        cmd.flow_write   = 1'b1;
        cmd.remote_write = 1'b1;
        cmd.code_load    = 1'b1;
        cmd.code         = ST_FLOW;
        state_next       = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // a client search step never reads past the end of the client list
  a_client_rd: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_client |-> !st.client_end) else $error("client read past end");
  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> in_ready) else $error("no return to idle after result");
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready) else $error("second beat taken while busy");
endmodule

/* src/ftab_dp.sv */
// ----------------------------------------------------------------------------
// ftab_dp
// Datapath: table memories, search index, counters and result register.
// ----------------------------------------------------------------------------
module ftab_dp #(
  parameter int CLIENTS = 16,
  parameter int REMOTES = 16,
  parameter int FLOWS   = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [23:0]          prefix,
  input  logic [31:0]          src_addr,
  input  logic [31:0]          dst_addr,
  input  logic [7:0]           protocol,
  input  logic [15:0]          src_port,
  input  logic [15:0]          dst_port,
  input  logic [15:0]          length,
  input  ftab_pkg::ftab_cmd_t  cmd,
  output ftab_pkg::ftab_stat_t st,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           status,
  output logic [3:0]           client_slot,
  output logic [3:0]           remote_slot,
  output logic [3:0]           flow_slot,
  output logic [31:0]          remote_packets,
  output logic [47:0]          remote_bytes,
  output logic [31:0]          remote_proto_count,
  output logic [4:0]           remote_connections,
  output logic [31:0]          flow_packets,
  output logic [47:0]          flow_bytes
);
  import ftab_pkg::*;

  localparam int NR   = CLIENTS * REMOTES;
  localparam int NF   = NR * FLOWS;
  localparam int CIW  = CLIENTS > 1 ? $clog2(CLIENTS) : 1;
  localparam int CCW  = $clog2(CLIENTS + 1);
  localparam int RCW  = $clog2(REMOTES + 1);
  localparam int FCW  = $clog2(FLOWS + 1);
  localparam int RAW  = NR > 1 ? $clog2(NR) : 1;
  localparam int FAW  = NF > 1 ? $clog2(NF) : 1;
  localparam int MAXN = CLIENTS > REMOTES ? (CLIENTS > FLOWS ? CLIENTS : FLOWS)
                                          : (REMOTES > FLOWS ? REMOTES : FLOWS);
  localparam int IW   = $clog2(MAXN + 1);
  localparam int RWW  = 32 + 32 + 48 + 32 + 32 + 32 + FCW;
  localparam int FWW  = 33 + 32 + 48;

  function automatic logic [31:0] inc32(input logic [31:0] a);
    logic [32:0] s;
    s = {1'b0, a} + 33'd1;
    return s[32] ? '1 : s[31:0];
  endfunction

  function automatic logic [47:0] add48(input logic [47:0] a, input logic [15:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {33'd0, b};
    return s[48] ? '1 : s[47:0];
  endfunction

  // latched item
  logic [31:0] in_src, in_dst;
  logic [7:0]  in_proto;
  logic [15:0] in_sp, in_dp, in_len;

  logic        sin, din;
  logic [31:0] cli, rem;
  logic [15:0] lport, rport;
  logic [32:0] key;

  logic [CCW-1:0] client_count;
  logic [IW-1:0]  idx;
  logic [CIW-1:0] c_reg;
  logic [RAW-1:0] rbase, ri;
  logic [FAW-1:0] fbase, fi;
  logic [RCW-1:0] rcnt;
  logic [FCW-1:0] fcnt;
  logic [IW-1:0]  r_reg, f_reg;
  stat_code_t     code;

  logic [31:0] r_addr, r_pkt, r_tcp, r_udp, r_icmp;
  logic [47:0] r_byt;
  logic [32:0] f_key;
  logic [31:0] f_pkt;
  logic [47:0] f_byt;

  // memory ports
  logic [7:0]     host_rdata;
  logic [RCW-1:0] rc_rdata, rc_wdata;
  logic [CIW-1:0] rc_waddr;
  logic [RWW-1:0] rw_rdata, rw_wdata;
  logic [FWW-1:0] fw_rdata, fw_wdata;
  logic [31:0]    rd_addr, rd_pkt, rd_tcp, rd_udp, rd_icmp;
  logic [47:0]    rd_byt;
  logic [FCW-1:0] rd_fcnt;
  logic [32:0]    fd_key;
  logic [31:0]    fd_pkt;
  logic [47:0]    fd_byt;

  // result field selects
  logic        out_client, out_remote, out_flow;
  logic [31:0] proto_cnt;

  assign sin   = (in_src[31:8] == prefix);
  assign din   = (in_dst[31:8] == prefix);
  assign cli   = sin ? in_src : in_dst;
  assign rem   = sin ? in_dst : in_src;
  assign lport = sin ? in_sp : in_dp;
  assign rport = sin ? in_dp : in_sp;
  assign key   = {in_proto == PROTO_UDP, lport, rport};

  assign {rd_addr, rd_pkt, rd_byt, rd_tcp, rd_udp, rd_icmp, rd_fcnt} = rw_rdata;
  assign {fd_key, fd_pkt, fd_byt} = fw_rdata;
  assign rw_wdata = {r_addr, r_pkt, r_byt, r_tcp, r_udp, r_icmp, fcnt};
  assign fw_wdata = {f_key, f_pkt, f_byt};
  assign rc_waddr = cmd.client_append ? client_count[CIW-1:0] : c_reg;
  assign rc_wdata = cmd.client_append ? '0 : RCW'(rcnt + RCW'(1));

  assign out_remote = (code == ST_RONLY) || (code == ST_FFULL) || (code == ST_FLOW);
  assign out_client = (code == ST_RFULL) || out_remote;
  assign out_flow   = (code == ST_FLOW);
  assign proto_cnt  = (in_proto == PROTO_TCP)  ? r_tcp  :
                      (in_proto == PROTO_UDP)  ? r_udp  :
                      (in_proto == PROTO_ICMP) ? r_icmp : 32'd0;

  assign st.is_client   = sin ^ din;
  assign st.flow_proto  = (in_proto == PROTO_TCP) || (in_proto == PROTO_UDP);
  assign st.client_end  = idx >= IW'(client_count);
  assign st.client_full = client_count == CCW'(CLIENTS);
  assign st.client_hit  = host_rdata == cli[7:0];
  assign st.remote_end  = idx >= IW'(rcnt);
  assign st.remote_full = rcnt == RCW'(REMOTES);
  assign st.remote_hit  = rd_addr == rem;
  assign st.flow_end    = idx >= IW'(fcnt);
  assign st.flow_full   = fcnt == FCW'(FLOWS);
  assign st.flow_hit    = fd_key == key;
  assign st.out_free    = !out_valid || out_ready;

  ftab_ram #(.WIDTH(8), .DEPTH(CLIENTS)) u_host (
    .clk(clk), .we(cmd.client_append), .waddr(client_count[CIW-1:0]),
    .wdata(cli[7:0]), .re(cmd.rd_client), .raddr(idx[CIW-1:0]), .rdata(host_rdata)
  );

  ftab_ram #(.WIDTH(RCW), .DEPTH(CLIENTS)) u_rcount (
    .clk(clk), .we(cmd.client_append || cmd.remote_append), .waddr(rc_waddr),
    .wdata(rc_wdata), .re(cmd.rd_rcount), .raddr(c_reg), .rdata(rc_rdata)
  );

  ftab_ram #(.WIDTH(RWW), .DEPTH(NR)) u_remote (
    .clk(clk), .we(cmd.remote_write), .waddr(ri), .wdata(rw_wdata),
    .re(cmd.rd_remote), .raddr(RAW'(rbase + RAW'(idx))), .rdata(rw_rdata)
  );

  ftab_ram #(.WIDTH(FWW), .DEPTH(NF)) u_flow (
    .clk(clk), .we(cmd.flow_write), .waddr(fi), .wdata(fw_wdata),
    .re(cmd.rd_flow), .raddr(FAW'(fbase + FAW'(idx))), .rdata(fw_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      client_count <= '0;
      idx          <= '0;
      out_valid    <= 1'b0;
      code         <= ST_NONE;
    end else begin
      if (cmd.client_append) begin
        client_count <= CCW'(client_count + CCW'(1));
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= IW'(idx + IW'(1));
      end
      if (cmd.code_load) begin
        code <= cmd.code;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_src   <= src_addr;
      in_dst   <= dst_addr;
      in_proto <= protocol;
      in_sp    <= src_port;
      in_dp    <= dst_port;
      in_len   <= length;
    end
    if (cmd.client_append) begin
      c_reg <= client_count[CIW-1:0];
      rbase <= RAW'(RAW'(client_count) * RAW'(REMOTES));
      rcnt  <= '0;
    end
    if (cmd.client_hit_load) begin
      c_reg <= idx[CIW-1:0];
      rbase <= RAW'(RAW'(idx) * RAW'(REMOTES));
    end
    if (cmd.rcount_load) begin
      rcnt <= rc_rdata;
    end
    if (cmd.remote_append) begin
      r_reg  <= IW'(rcnt);
      ri     <= RAW'(rbase + RAW'(rcnt));
      r_addr <= rem;
      r_pkt  <= '0;
      r_byt  <= '0;
      r_tcp  <= '0;
      r_udp  <= '0;
      r_icmp <= '0;
      fcnt   <= '0;
    end
    if (cmd.remote_hit_load) begin
      r_reg  <= idx;
      ri     <= RAW'(rbase + RAW'(idx));
      r_addr <= rd_addr;
      r_pkt  <= rd_pkt;
      r_byt  <= rd_byt;
      r_tcp  <= rd_tcp;
      r_udp  <= rd_udp;
      r_icmp <= rd_icmp;
      fcnt   <= rd_fcnt;
    end
    if (cmd.remote_update) begin
      r_pkt <= inc32(r_pkt);
      r_byt <= add48(r_byt, in_len);
      if (in_proto == PROTO_TCP) begin
        r_tcp <= inc32(r_tcp);
      end
      if (in_proto == PROTO_UDP) begin
        r_udp <= inc32(r_udp);
      end
      if (in_proto == PROTO_ICMP) begin
        r_icmp <= inc32(r_icmp);
      end
      fbase <= FAW'(FAW'(ri) * FAW'(FLOWS));
    end
    if (cmd.flow_append) begin
      f_reg <= IW'(fcnt);
      fi    <= FAW'(fbase + FAW'(fcnt));
      fcnt  <= FCW'(fcnt + FCW'(1));
      f_key <= key;
      f_pkt <= '0;
      f_byt <= '0;
    end
    if (cmd.flow_hit_load) begin
      f_reg <= idx;
      fi    <= FAW'(fbase + FAW'(idx));
      f_key <= fd_key;
      f_pkt <= fd_pkt;
      f_byt <= fd_byt;
    end
    if (cmd.flow_update) begin
      f_pkt <= inc32(f_pkt);
      f_byt <= add48(f_byt, in_len);
    end
    if (cmd.out_load) begin
      status             <= code;
      client_slot        <= out_client ? 4'(c_reg) : 4'd0;
      remote_slot        <= out_remote ? 4'(r_reg) : 4'd0;
      remote_packets     <= out_remote ? r_pkt : 32'd0;
      remote_bytes       <= out_remote ? r_byt : 48'd0;
      remote_connections <= out_remote ? 5'(fcnt) : 5'd0;
      remote_proto_count <= out_remote ? proto_cnt : 32'd0;
      flow_slot          <= out_flow ? 4'(f_reg) : 4'd0;
      flow_packets       <= out_flow ? f_pkt : 32'd0;
      flow_bytes         <= out_flow ? f_byt : 48'd0;
    end
  end

  a_ccount: assert property (@(posedge clk) disable iff (rst)
    client_count <= CCW'(CLIENTS)) else $error("client count overflow");
  a_rcount: assert property (@(posedge clk) disable iff (rst)
    cmd.rcount_load |=> rcnt <= RCW'(REMOTES)) else $error("remote count overflow");
  a_fcount: assert property (@(posedge clk) disable iff (rst)
    cmd.flow_append |=> fcnt <= FCW'(FLOWS)) else $error("flow count overflow");
endmodule

/* src/flow_statistics_table_core.sv */
// ----------------------------------------------------------------------------
// flow_statistics_table_core
// Per-flow traffic counter table for IPv4 packet summaries.
// ----------------------------------------------------------------------------
// Each beat on the input carries one packet summary and yields exactly one
// result beat. A packet counts only if exactly one address lies in the /24
// client network set by client_prefix (address 0, reset 172.31.66). The block
// searches the client list, then the remotes of that client, then for TCP/UDP
// the flows of that remote, each in insertion order, appending on a miss.
// The searches walk one entry at a time, a read and then a compare, on
// tables with one write port, one read port and registered reads. Only one
// item is in work at a time; a finished result waits in the output register
// while the next beat is taken. All tables start empty after reset, with no
// clearing pass.
// ----------------------------------------------------------------------------
module flow_statistics_table_core #(
  parameter int CLIENTS = 16,
  parameter int REMOTES = 16,
  parameter int FLOWS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  input  logic [7:0]  protocol,
  input  logic [15:0] src_port,
  input  logic [15:0] dst_port,
  input  logic [15:0] length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [3:0]  client_slot,
  output logic [3:0]  remote_slot,
  output logic [3:0]  flow_slot,
  output logic [31:0] remote_packets,
  output logic [47:0] remote_bytes,
  output logic [31:0] remote_proto_count,
  output logic [4:0]  remote_connections,
  output logic [31:0] flow_packets,
  output logic [47:0] flow_bytes,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ftab_pkg::*;

  logic [23:0] client_prefix;
  ftab_cmd_t   cmd;
  ftab_stat_t  st;

  // zero-wait APB; one register at byte address 0
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {8'd0, client_prefix} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      client_prefix <= PREFIX_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      client_prefix <= pwdata[23:0];
    end
  end

  ftab_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .st(st), .cmd(cmd)
  );

  ftab_dp #(.CLIENTS(CLIENTS), .REMOTES(REMOTES), .FLOWS(FLOWS)) u_dp (
    .clk(clk), .rst(rst), .prefix(client_prefix),
    .src_addr(src_addr), .dst_addr(dst_addr), .protocol(protocol),
    .src_port(src_port), .dst_port(dst_port), .length(length),
    .cmd(cmd), .st(st), .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .client_slot(client_slot), .remote_slot(remote_slot),
    .flow_slot(flow_slot), .remote_packets(remote_packets),
    .remote_bytes(remote_bytes), .remote_proto_count(remote_proto_count),
    .remote_connections(remote_connections), .flow_packets(flow_packets),
    .flow_bytes(flow_bytes)
  );
endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for flow_statistics_table_core.
// ----------------------------------------------------------------------------
// Packet summary beats go in on a valid/ready channel. Result beats are checked
// field by field against an in-bench copy of the client/remote/flow tables,
// kept up to date at every accepted input beat. Both sides idle at random.
// Several client prefixes are programmed over the APB port, and the bench
// checks each write by reading the register back. A long output stall
// makes the block back up its input.
// ----------------------------------------------------------------------------
module tb;
  import ftab_pkg::*;

  localparam int NCLI = 16;
  localparam int NREM = 16;
  localparam int NFLW = 16;
  localparam logic [2:0] REG_CLIENT_PREFIX = 3'd0;
  localparam int WDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  proto;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] len;
  } pkt_t;

  typedef struct packed {
    stat_code_t  status;
    logic [3:0]  cslot;
    logic [3:0]  rslot;
    logic [3:0]  fslot;
    logic [31:0] rpkts;
    logic [47:0] rbytes;
    logic [31:0] rproto;
    logic [4:0]  rconn;
    logic [31:0] fpkts;
    logic [47:0] fbytes;
  } tally_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [7:0]  protocol;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [15:0] length;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  status;
  logic [3:0]  client_slot;
  logic [3:0]  remote_slot;
  logic [3:0]  flow_slot;
  logic [31:0] remote_packets;
  logic [47:0] remote_bytes;
  logic [31:0] remote_proto_count;
  logic [4:0]  remote_connections;
  logic [31:0] flow_packets;
  logic [47:0] flow_bytes;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  flow_statistics_table_core i_dut (.*);

  // Shadow copy of the tables
  logic [23:0] net_prefix;
  int          n_clients;
  logic [7:0]  host_byte [NCLI];
  int          n_remotes [NCLI];
  logic [31:0] rem_addr  [NCLI*NREM];
  logic [31:0] rem_pkts  [NCLI*NREM];
  logic [47:0] rem_bytes [NCLI*NREM];
  logic [31:0] rem_tcp   [NCLI*NREM];
  logic [31:0] rem_udp   [NCLI*NREM];
  logic [31:0] rem_icmp  [NCLI*NREM];
  int          n_flows   [NCLI*NREM];
  logic [32:0] flw_key   [NCLI*NREM*NFLW];
  logic [31:0] flw_pkts  [NCLI*NREM*NFLW];
  logic [47:0] flw_bytes [NCLI*NREM*NFLW];

  tally_t      tally_q[$];
  int          errors;
  int          tx_max;
  int          rx_max;
  bit          hold_rx;
  int          idle_cycles;
  logic [31:0] far_pool [12];
  logic [15:0] port_pool [4];

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic logic [31:0] inc32(logic [31:0] a);
    return (a == 32'hFFFF_FFFF) ? a : a + 32'd1;
  endfunction

  function automatic logic [47:0] add48(logic [47:0] a, logic [15:0] b);
    logic [48:0] s;
    s = {1'b0, a} + b;
    return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
  endfunction

  // Walk client, remote and flow lists; append on a miss; bump counters.
  function automatic tally_t count_packet(pkt_t p);
    tally_t t;
    logic [31:0] cli, rem;
    logic [15:0] lport, rport;
    logic [32:0] key;
    bit s_in, d_in;
    int c, r, f, ri, fi;
    t = '0;
    s_in = (p.src[31:8] == net_prefix);
    d_in = (p.dst[31:8] == net_prefix);
    if (s_in == d_in) return t;
    if (s_in) begin
      cli = p.src; rem = p.dst; lport = p.sport; rport = p.dport;
    end else begin
      cli = p.dst; rem = p.src; lport = p.dport; rport = p.sport;
    end
    for (c = 0; c < n_clients; c++) if (host_byte[c] == cli[7:0]) break;
    if (c == n_clients) begin
      if (n_clients >= NCLI) begin
        t.status = ST_CFULL;
        return t;
      end
      host_byte[c] = cli[7:0];
      n_remotes[c] = 0;
      n_clients++;
    end
    t.cslot = c[3:0];
    for (r = 0; r < n_remotes[c]; r++) if (rem_addr[c*NREM + r] == rem) break;
    if (r == n_remotes[c]) begin
      if (n_remotes[c] >= NREM) begin
        t.status = ST_RFULL;
        return t;
      end
      ri = c*NREM + r;
      rem_addr[ri] = rem;
      rem_pkts[ri] = '0; rem_bytes[ri] = '0;
      rem_tcp[ri] = '0; rem_udp[ri] = '0; rem_icmp[ri] = '0;
      n_flows[ri] = 0;
      n_remotes[c]++;
    end
    ri = c*NREM + r;
    t.rslot = r[3:0];
    rem_pkts[ri] = inc32(rem_pkts[ri]);
    rem_bytes[ri] = add48(rem_bytes[ri], p.len);
    if (p.proto == PROTO_TCP) begin
      rem_tcp[ri] = inc32(rem_tcp[ri]); t.rproto = rem_tcp[ri];
    end else if (p.proto == PROTO_UDP) begin
      rem_udp[ri] = inc32(rem_udp[ri]); t.rproto = rem_udp[ri];
    end else if (p.proto == PROTO_ICMP) begin
      rem_icmp[ri] = inc32(rem_icmp[ri]); t.rproto = rem_icmp[ri];
    end
    t.rpkts = rem_pkts[ri];
    t.rbytes = rem_bytes[ri];
    t.rconn = n_flows[ri][4:0];
    if (p.proto != PROTO_TCP && p.proto != PROTO_UDP) begin
      t.status = ST_RONLY;
      return t;
    end
    key = {p.proto == PROTO_UDP, lport, rport};
    for (f = 0; f < n_flows[ri]; f++) if (flw_key[ri*NFLW + f] == key) break;
    if (f == n_flows[ri]) begin
      if (n_flows[ri] >= NFLW) begin
        t.status = ST_FFULL;
        return t;
      end
      fi = ri*NFLW + f;
      flw_key[fi] = key; flw_pkts[fi] = '0; flw_bytes[fi] = '0;
      n_flows[ri]++;
    end
    fi = ri*NFLW + f;
    flw_pkts[fi] = inc32(flw_pkts[fi]);
    flw_bytes[fi] = add48(flw_bytes[fi], p.len);
    t.status = ST_FLOW;
    t.fslot = f[3:0];
    t.rconn = n_flows[ri][4:0];
    t.fpkts = flw_pkts[fi];
    t.fbytes = flw_bytes[fi];
    return t;
  endfunction

  // Offer one beat after a random gap; keep valid high for the next beat.
  task automatic send_pkt(pkt_t p);
    int gap;
    gap = $urandom_range(0, tx_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_addr <= p.src; dst_addr <= p.dst; protocol <= p.proto;
    src_port <= p.sport; dst_port <= p.dport; length <= p.len;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    tally_q.push_back(count_packet(p));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (tally_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Program the prefix during idle, then read it back.
  task automatic set_prefix(logic [23:0] value);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_CLIENT_PREFIX;
    pwdata <= {8'h00, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    net_prefix = value;
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[23:0] !== value) begin
      $display("%0t prefix readback: expected %h actual %h", $time, value, prdata[23:0]);
      errors++;
    end
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic pkt_t mk_pkt(logic [31:0] s, logic [31:0] d, logic [7:0] pr,
                                  logic [15:0] sp, logic [15:0] dp, logic [15:0] ln);
    pkt_t p;
    p = '{s, d, pr, sp, dp, ln};
    return p;
  endfunction

  // Mostly well-formed client traffic from small pools so lookups hit and
  // lists fill up; the rest is noise.
  function automatic pkt_t rand_pkt();
    pkt_t p;
    logic [31:0] cli, rem;
    logic [15:0] lp, rp;
    int k;
    k = $urandom_range(0, 9);
    p.len = ($urandom_range(0, 15) == 0) ? 16'hFFFF : 16'($urandom);
    if (k == 0) begin
      p.src = $urandom; p.dst = $urandom; p.proto = 8'($urandom);
      p.sport = 16'($urandom); p.dport = 16'($urandom);
      if ($urandom_range(0, 1)) p.src[31:8] = net_prefix;
      if ($urandom_range(0, 1)) p.dst[31:8] = net_prefix;
      return p;
    end
    cli = {net_prefix, ($urandom_range(0, 11) == 0) ? 8'($urandom)
                                                      : 8'($urandom_range(0, 13))};
    rem = ($urandom_range(0, 9) == 0) ? $urandom : far_pool[$urandom_range(0, 11)];
    lp = ($urandom_range(0, 9) == 0) ? 16'($urandom) : port_pool[$urandom_range(0, 3)];
    rp = ($urandom_range(0, 9) == 0) ? 16'($urandom) : port_pool[$urandom_range(0, 3)];
    case ($urandom_range(0, 9))
      0, 1, 2, 3: p.proto = PROTO_TCP;
      4, 5, 6:    p.proto = PROTO_UDP;
      7:          p.proto = PROTO_ICMP;
      default:    p.proto = 8'($urandom);
    endcase
    if ($urandom_range(0, 1)) begin
      p.src = cli; p.dst = rem; p.sport = lp; p.dport = rp;
    end else begin
      p.src = rem; p.dst = cli; p.sport = rp; p.dport = lp;
    end
    return p;
  endfunction

  task automatic report(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s: expected %h actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Check every result beat against the oldest pending tally.
  always @(posedge clk) begin
    tally_t t;
    if (!rst && out_valid && out_ready) begin
      if (tally_q.size() == 0) begin
        $display("%0t unexpected result beat: expected none actual status %0d",
                 $time, status);
        errors++;
      end else begin
        t = tally_q.pop_front();
        report("status", t.status, status);
        report("client_slot", t.cslot, client_slot);
        report("remote_slot", t.rslot, remote_slot);
        report("flow_slot", t.fslot, flow_slot);
        report("remote_packets", t.rpkts, remote_packets);
        report("remote_bytes", t.rbytes, remote_bytes);
        report("remote_proto_count", t.rproto, remote_proto_count);
        report("remote_connections", t.rconn, remote_connections);
        report("flow_packets", t.fpkts, flow_packets);
        report("flow_bytes", t.fbytes, flow_bytes);
      end
    end
  end

  // Receiver: stall a random number of cycles per beat, or hold off for a
  // long stretch when asked.
  initial begin
    int n;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (hold_rx) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
      end
      n = $urandom_range(0, rx_max);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Watchdog: count cycles with no beat on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic test_directed;
    logic [31:0] c0, c1;
    c0 = {PREFIX_RESET, 8'h00};
    c1 = {PREFIX_RESET, 8'hFF};
    send_pkt(mk_pkt(32'h0, 32'hFFFF_FFFF, PROTO_TCP, 16'h0, 16'hFFFF, 16'hFFFF));
    send_pkt(mk_pkt(c0, c1, PROTO_UDP, 16'h1, 16'h2, 16'h40));
    send_pkt(mk_pkt(c0, 32'hFFFF_FFFF, PROTO_TCP, 16'h0, 16'hFFFF, 16'hFFFF));
    send_pkt(mk_pkt(c0, 32'hFFFF_FFFF, PROTO_TCP, 16'h0, 16'hFFFF, 16'hFFFF));
    send_pkt(mk_pkt(32'hFFFF_FFFF, c0, PROTO_TCP, 16'hFFFF, 16'h0, 16'h0));
    send_pkt(mk_pkt(32'hFFFF_FFFF, c0, PROTO_UDP, 16'hFFFF, 16'h0, 16'h1));
    send_pkt(mk_pkt(c0, 32'hFFFF_FFFF, PROTO_ICMP, 16'h0, 16'h0, 16'h54));
    send_pkt(mk_pkt(c0, 32'hFFFF_FFFF, 8'h00, 16'h0, 16'h0, 16'h20));
    send_pkt(mk_pkt(c0, 32'hFFFF_FFFF, 8'hFF, 16'hAAAA, 16'h5555, 16'h20));
    send_pkt(mk_pkt(c1, 32'h0, PROTO_TCP, 16'h5555, 16'hAAAA, 16'h5DC));
    send_pkt(mk_pkt(32'h0, c1, PROTO_UDP, 16'h35, 16'hC000, 16'h80));
    send_pkt(mk_pkt(c1, 32'h0A00_0001, PROTO_ICMP, 16'h0, 16'h0, 16'h1C));
    send_pkt(mk_pkt(c1, 32'h0, PROTO_TCP, 16'h5555, 16'hAAAA, 16'hFFFF));
    drain();
  endtask

  // Fill one remote with flows, then one client with remotes, then clients.
  task automatic test_table_limits;
    logic [31:0] cli;
    cli = {net_prefix, 8'hC3};
    for (int i = 0; i <= NFLW; i++)
      send_pkt(mk_pkt(cli, 32'h0808_0808, PROTO_TCP, 16'(1000 + i), 16'd443, 16'd60));
    send_pkt(mk_pkt(cli, 32'h0808_0808, PROTO_ICMP, 16'h0, 16'h0, 16'd84));
    send_pkt(mk_pkt(32'h0808_0808, cli, PROTO_UDP, 16'd53, 16'd1000, 16'd90));
    for (int i = 0; i <= NREM; i++)
      send_pkt(mk_pkt(32'h0909_0000 + i, cli, PROTO_UDP, 16'd53, 16'd5000, 16'd70));
    for (int i = 0; i <= NCLI; i++)
      send_pkt(mk_pkt({net_prefix, 8'(8'h80 + i)}, 32'h0101_0101, PROTO_TCP,
                      16'd22, 16'd22, 16'd40));
    drain();
  endtask

  task automatic test_random_phase(int count);
    for (int i = 0; i < count; i++) begin
      // a stretch of back-to-back beats on both sides
      if (i == count / 2) begin
        tx_max = 0; rx_max = 0;
      end else if (i == count / 2 + 40) begin
        tx_max = 18; rx_max = 18;
      end
      send_pkt(rand_pkt());
    end
    drain();
  endtask

  task automatic test_backpressure;
    hold_rx = 1'b1;
    tx_max = 0;
    for (int i = 0; i < 30; i++) send_pkt(rand_pkt());
    tx_max = 18;
    drain();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0; src_addr = '0; dst_addr = '0; protocol = '0;
    src_port = '0; dst_port = '0; length = '0; out_ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    errors = 0; tx_max = 18; rx_max = 18; hold_rx = 1'b0; idle_cycles = 0;
    net_prefix = PREFIX_RESET;
    n_clients = 0;
    foreach (n_remotes[i]) n_remotes[i] = 0;
    foreach (far_pool[i]) far_pool[i] = $urandom;
    port_pool[0] = 16'h0000;
    port_pool[1] = 16'hFFFF;
    port_pool[2] = 16'($urandom);
    port_pool[3] = 16'($urandom);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_phase(400);
    set_prefix(24'hFFFFFF);
    test_random_phase(250);
    set_prefix(24'h000000);
    test_random_phase(250);
    set_prefix(24'($urandom));
    test_random_phase(200);
    test_backpressure();
    set_prefix(PREFIX_RESET);
    test_random_phase(150);
    test_table_limits();

    repeat (150) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
